@@ hw/rtl/bhc_pkg.sv @@
`timescale 1ns / 1ps

package bhc_pkg;

  // item kinds, code 3 is unused
  typedef enum logic [1:0] {
    KindEdge    = 2'd0,
    KindTick    = 2'd1,
    KindRestart = 2'd2
  } kind_e;

  // gate pattern with no low-side drive
  localparam logic [5:0]  NoDrive          = 6'h3F;
  localparam logic [15:0] DutyCeilingReset = 16'd1440;
  localparam logic [15:0] EdgeCountMax     = 16'hFFFF;

  // low-side drive mask per {direction, hall}
  localparam logic [5:0] DriveTable [16] = '{
    6'h1F, 6'h1F, 6'h37, 6'h1F, 6'h2F, 6'h2F, 6'h37, 6'h37,
    6'h1F, 6'h37, 6'h2F, 6'h2F, 6'h1F, 6'h37, 6'h1F, 6'h2F
  };

  // gate phase per {direction, hall}
  localparam logic [1:0] PhaseTable [16] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2
  };

  typedef struct packed {
    logic up;
    logic down;
  } hall_step_t;

  // position step from hall level and edge flags
  function automatic hall_step_t hall_step(input logic [2:0] hall, input logic [2:0] flags);
    hall_step_t s;
    s = '0;
    case (hall)
      3'd1: begin
        s.up   = (flags == 3'd2);
        s.down = (flags == 3'd4);
      end
      3'd2, 3'd5: begin
        s.up   = (flags == 3'd4);
        s.down = (flags == 3'd1);
      end
      3'd3, 3'd4: begin
        s.up   = (flags == 3'd1);
        s.down = (flags == 3'd2);
      end
      3'd6: begin
        s.up   = (flags == 3'd2);
        s.down = (flags == 3'd4);
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  hall_bits;
    logic [2:0]  edge_flags;
    logic        direction;
    logic [15:0] duty_limit;
    logic [7:0]  ramp_step;
    logic [15:0] count_limit;
    logic [15:0] start_value;
  } item_t;

  typedef struct packed {
    logic [5:0]         drive_mask;
    logic [1:0]         low_phase;
    logic [1:0]         high_phase;
    logic signed [31:0] shaft_position;
    logic [15:0]        duty;
    logic [15:0]        compare_value;
    logic               duty_updated;
  } result_t;

endpackage

@@ hw/rtl/bhc_core.sv @@
`timescale 1ns / 1ps

module bhc_core import bhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  input  logic [15:0] duty_ceiling_i,
  output result_t     res_o
);

  logic [16:0]        ramp_q, ramp_d, ramp_n, ramp_clamp;
  logic [15:0]        ec_q, ec_d, ec_n;
  logic signed [31:0] pos_q, pos_d;
  logic [15:0]        duty_q, duty_d;
  logic               apply;
  logic [3:0]         idx;
  hall_step_t         step;
  logic [16:0]        step_ext;
  logic [5:0]         drive_mask;
  logic [1:0]         low_phase, high_phase;
  logic               updated;

  assign idx      = {item_i.direction, item_i.hall_bits};
  assign step     = hall_step(item_i.hall_bits, item_i.edge_flags);
  assign step_ext = {9'd0, item_i.ramp_step};

  // per-kind state update
  always_comb begin
    ramp_n     = ramp_q;
    ec_n       = ec_q;
    pos_d      = pos_q;
    apply      = 1'b0;
    drive_mask = NoDrive;
    low_phase  = 2'd0;
    high_phase = 2'd0;
    case (item_i.kind)
      KindEdge: begin
        if (item_i.edge_flags != 3'd0) begin
          drive_mask = DriveTable[idx];
          low_phase  = PhaseTable[idx];
          high_phase = PhaseTable[idx];
          if (step.up) begin
            pos_d = pos_q + 32'sd1;
          end else if (step.down) begin
            pos_d = pos_q - 32'sd1;
          end
          ec_n   = (ec_q == EdgeCountMax) ? ec_q : ec_q + 16'd1;
          ramp_n = (ramp_q > step_ext) ? ramp_q - step_ext : 17'd0;
          apply  = 1'b1;
        end
      end
      KindTick: begin
        if (duty_q <= item_i.duty_limit && ramp_q < {1'b0, duty_ceiling_i}) begin
          ramp_n = ramp_q + step_ext;
        end
        apply = 1'b1;
      end
      KindRestart: begin
        ramp_n = {1'b0, item_i.start_value};
        ec_n   = 16'd0;
      end
      default: ;
    endcase
  end

  // ramp drives the duty once the count reaches its limit
  always_comb begin
    ramp_clamp = ramp_n;
    if (ramp_clamp > {1'b0, item_i.duty_limit}) begin
      ramp_clamp = {1'b0, item_i.duty_limit};
    end
    if (ramp_clamp > {1'b0, duty_ceiling_i}) begin
      ramp_clamp = {1'b0, duty_ceiling_i};
    end
    ramp_d  = ramp_n;
    ec_d    = ec_n;
    duty_d  = duty_q;
    updated = 1'b0;
    if (apply && ec_n >= item_i.count_limit) begin
      ec_d    = item_i.count_limit;
      duty_d  = ramp_clamp[15:0];
      updated = 1'b1;
    end
  end

  // result fields from the new state
  always_comb begin
    res_o.drive_mask     = drive_mask;
    res_o.low_phase      = low_phase;
    res_o.high_phase     = high_phase;
    res_o.shaft_position = pos_d;
    res_o.duty           = duty_d;
    res_o.compare_value  = (duty_ceiling_i > duty_d) ? duty_ceiling_i - duty_d : 16'd0;
    res_o.duty_updated   = updated;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q <= '0;
      ec_q   <= '0;
      pos_q  <= '0;
      duty_q <= '0;
    end else if (fire_i) begin
      ramp_q <= ramp_d;
      ec_q   <= ec_d;
      pos_q  <= pos_d;
      duty_q <= duty_d;
    end
  end

  a_duty_within_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.duty_updated |-> res_o.duty <= duty_ceiling_i)
    else $error("updated duty above ceiling");

  a_restart_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.kind == KindRestart |=> ec_q == 16'd0)
    else $error("restart did not clear edge count");

  a_count_held_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.duty_updated |=> ec_q == $past(item_i.count_limit))
    else $error("edge count not held at limit");

  a_flagless_edge_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.kind == KindEdge && item_i.edge_flags == 3'd0
    |=> pos_q == $past(pos_q) && ec_q == $past(ec_q) && ramp_q == $past(ramp_q))
    else $error("edge without flags changed state");

endmodule

@@ hw/rtl/bldc_hall_commutator_duty_ramp.sv @@
`timescale 1ns / 1ps

// Six-step hall commutator with a duty ramp.
// Input channel: in_valid_i / in_stall_o with one port per field. kind_i selects
// a hall edge, a ramp tick or a ramp restart. A beat is taken when valid is high
// and stall is low.
// Output channel: out_valid_o / out_stall_i, one result beat per input beat,
// carrying the gate drive pattern, shaft position, duty and compare value.
// Configuration: cfg_we_i writes cfg_wdata_i into the duty ceiling register;
// write it only while no beat is in flight.
// Path: a taken beat lands in the input register, is evaluated against the
// state and is written to the result register when it fires; while out_stall_i
// holds the result register, the beat waits in the input register.
// Throughput: one beat per cycle while out_stall_i is low; all work is a single
// pass of adds and compares between the input register and the result register.
// Stall: while the result register is held by out_stall_i, the input register
// keeps one more beat and in_stall_o rises only when both are full.
// Reset: ramp, edge count, shaft position and duty clear to zero, the ceiling
// returns to 1440 and both channels come up empty.
module bldc_hall_commutator_duty_ramp import bhc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         hall_bits_i,
  input  logic [2:0]         edge_flags_i,
  input  logic               direction_i,
  input  logic [15:0]        duty_limit_i,
  input  logic [7:0]         ramp_step_i,
  input  logic [15:0]        count_limit_i,
  input  logic [15:0]        start_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         drive_mask_o,
  output logic [1:0]         low_phase_o,
  output logic [1:0]         high_phase_o,
  output logic signed [31:0] shaft_position_o,
  output logic [15:0]        duty_o,
  output logic [15:0]        compare_value_o,
  output logic               duty_updated_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic        s1_valid_q, s1_valid_d;
  item_t       s1_item_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic [15:0] ceiling_q;
  logic        adv, fire, in_accept;

  // handshake control
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ceiling_q   <= DutyCeilingReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ceiling_q <= cfg_wdata_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.kind        <= kind_i;
      s1_item_q.hall_bits   <= hall_bits_i;
      s1_item_q.edge_flags  <= edge_flags_i;
      s1_item_q.direction   <= direction_i;
      s1_item_q.duty_limit  <= duty_limit_i;
      s1_item_q.ramp_step   <= ramp_step_i;
      s1_item_q.count_limit <= count_limit_i;
      s1_item_q.start_value <= start_value_i;
    end
  end

  // commutation and ramp evaluation
  bhc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (s1_item_q),
    .duty_ceiling_i (ceiling_q),
    .res_o          (res_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_mask_o     = res_q.drive_mask;
  assign low_phase_o      = res_q.low_phase;
  assign high_phase_o     = res_q.high_phase;
  assign shaft_position_o = res_q.shaft_position;
  assign duty_o           = res_q.duty;
  assign compare_value_o  = res_q.compare_value;
  assign duty_updated_o   = res_q.duty_updated;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room available");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("evaluated beat produced no result");

  a_held_beat_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("pending beat lost while output stalled");

endmodule
